### hw/rtl/egts_pkg.sv
// shared types and constants of the energy gated task scheduler
`timescale 1ns / 1ps

package egts_pkg;

  // default configuration
  localparam int unsigned MaxTasksDefault   = 256;
  localparam int unsigned EnergyBitsDefault = 16;

  // fixed field widths
  localparam int unsigned EnergyInW = 16;
  localparam int unsigned IndexOutW = 8;

  // item opcodes
  localparam logic OpAdd   = 1'b0;
  localparam logic OpVisit = 1'b1;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } egts_state_e;

  // write commands from the controller to the task store
  typedef struct packed {
    logic add_we;     // store a new requirement and clear its mark
    logic mark_we;    // set the completion mark of the visited task
    logic clear_all;  // drop every completion mark (new round)
  } egts_wr_t;

endpackage

### hw/rtl/egts_store.sv
// task store: requirement memory and completion marks
`timescale 1ns / 1ps

module egts_store import egts_pkg::*; #(
  parameter int unsigned MAX_TASKS   = MaxTasksDefault,
  parameter int unsigned ENERGY_BITS = EnergyBitsDefault,
  localparam int unsigned IdxW       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  egts_wr_t               wr_i,
  input  logic [IdxW-1:0]        add_addr_i,
  input  logic [ENERGY_BITS-1:0] add_need_i,
  input  logic [IdxW-1:0]        mark_addr_i,
  input  logic [IdxW-1:0]        rd_addr_i,
  output logic [ENERGY_BITS-1:0] rd_need_o,
  output logic                   rd_done_o
);

  logic [ENERGY_BITS-1:0] need_mem [MAX_TASKS];
  logic                   tag_mem  [MAX_TASKS];
  logic [ENERGY_BITS-1:0] rd_need_q;
  logic                   rd_tag_q;
  logic                   round_q;

  // requirement table, synchronous read every cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.add_we) begin
      need_mem[add_addr_i] <= add_need_i;
    end
    rd_need_q <= need_mem[rd_addr_i];
  end

  // round tags: a task is complete when its tag equals the current round bit,
  // an add writes the opposite bit and a mark writes the current one
  always_ff @(posedge clk_i) begin
    if (wr_i.add_we) begin
      tag_mem[add_addr_i] <= ~round_q;
    end else if (wr_i.mark_we) begin
      tag_mem[mark_addr_i] <= round_q;
    end
    rd_tag_q <= tag_mem[rd_addr_i];
  end

  // a round reset flips the round bit, which drops every mark at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= 1'b0;
    end else if (wr_i.clear_all) begin
      round_q <= ~round_q;
    end
  end

  assign rd_need_o = rd_need_q;
  assign rd_done_o = (rd_tag_q == round_q);

endmodule

### hw/rtl/energy_gated_task_scheduler.sv
// top level of the energy gated task scheduler
`timescale 1ns / 1ps

// Keeps a table of one-shot tasks and walks them in passes. An add item stores
// a task's energy requirement (refused with add_accepted low once MAX_TASKS
// tasks are held). A visit item checks the next task of the pass: a task
// already complete is only counted, any other task fires (run_task) when
// energy_now is strictly above its requirement and condition_met is high.
// When a pass ends with every task complete, all marks are dropped and
// round_reset is reported. Each item gives exactly one result item.
// An add resolves at once, a visit goes through ST_EVAL, one item in flight
// at a time; the visit needs the synchronous read of the requirement memory
// before the compare and mark write-back. Completion marks are a one-bit
// round tag per task in a second memory: a task is complete when its tag
// matches the current round bit, so a round reset just flips that bit and
// there is no clearing pass after reset.
// Energy values use their low ENERGY_BITS bits.

module energy_gated_task_scheduler import egts_pkg::*; #(
  parameter int unsigned MAX_TASKS   = MaxTasksDefault,
  parameter int unsigned ENERGY_BITS = EnergyBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [EnergyInW-1:0] task_energy_need_i,
  input  logic [EnergyInW-1:0] energy_now_i,
  input  logic                 condition_met_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IndexOutW-1:0] task_index_o,
  output logic                 add_accepted_o,
  output logic                 run_task_o,
  output logic                 was_complete_o,
  output logic                 pass_end_o,
  output logic                 round_reset_o
);

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);

  egts_state_e state_q, state_d;

  logic [CntW-1:0] task_count_q, task_count_d;
  logic [IdxW-1:0] visit_pos_q, visit_pos_d;
  logic [CntW-1:0] done_in_pass_q, done_in_pass_d;

  // visit operands held for the evaluation cycle
  logic [ENERGY_BITS-1:0] energy_q;
  logic                   cond_q;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [IndexOutW-1:0] task_index_q, task_index_d;
  logic                 add_acc_q, add_acc_d;
  logic                 run_q, run_d;
  logic                 was_q, was_d;
  logic                 pend_q, pend_d;
  logic                 rreset_q, rreset_d;

  logic                   in_acc;
  logic                   out_acc;
  logic [31:0]            need_ext;
  logic [31:0]            energy_ext;
  logic [ENERGY_BITS-1:0] need_w;
  logic [ENERGY_BITS-1:0] energy_w;
  egts_wr_t               wr;
  logic [ENERGY_BITS-1:0] rd_need;
  logic                   rd_done;
  logic                   table_full;
  logic                   visit_run;
  logic                   visit_hit;
  logic [CntW-1:0]        dip_next;
  logic                   last_task;

  // one item at a time; every item also needs the result slot to be free
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  // energy values narrowed or widened to ENERGY_BITS
  assign need_ext   = {16'b0, task_energy_need_i};
  assign energy_ext = {16'b0, energy_now_i};
  assign need_w     = need_ext[ENERGY_BITS-1:0];
  assign energy_w   = energy_ext[ENERGY_BITS-1:0];

  assign table_full = task_count_q >= CntW'(MAX_TASKS);

  // visit decision, operands come from the store in the cycle after accept
  assign visit_hit = rd_done;
  assign visit_run = !rd_done && (energy_q > rd_need) && cond_q;
  assign dip_next  = done_in_pass_q + CntW'(visit_hit || visit_run);
  assign last_task = (CntW'(visit_pos_q) + CntW'(1)) >= task_count_q;

  always_comb begin
    state_d        = state_q;
    task_count_d   = task_count_q;
    visit_pos_d    = visit_pos_q;
    done_in_pass_d = done_in_pass_q;
    out_valid_d    = out_valid_q && !out_acc;
    task_index_d   = task_index_q;
    add_acc_d      = add_acc_q;
    run_d          = run_q;
    was_d          = was_q;
    pend_d         = pend_q;
    rreset_d       = rreset_q;
    wr             = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == OpAdd) begin
            // add resolves at once, no table read needed
            out_valid_d  = 1'b1;
            run_d        = 1'b0;
            was_d        = 1'b0;
            pend_d       = 1'b0;
            rreset_d     = 1'b0;
            if (!table_full) begin
              wr.add_we    = 1'b1;
              task_count_d = task_count_q + CntW'(1);
              task_index_d = IndexOutW'(task_count_q[IdxW-1:0]);
              add_acc_d    = 1'b1;
            end else begin
              task_index_d = '0;
              add_acc_d    = 1'b0;
            end
          end else begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        // result slot is empty here: it was free when the visit was taken
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        add_acc_d   = 1'b0;
        if (task_count_q == '0) begin
          // empty round counts as complete
          task_index_d   = '0;
          run_d          = 1'b0;
          was_d          = 1'b0;
          pend_d         = 1'b1;
          rreset_d       = 1'b1;
          visit_pos_d    = '0;
          done_in_pass_d = '0;
        end else begin
          task_index_d = IndexOutW'(visit_pos_q);
          run_d        = visit_run;
          was_d        = visit_hit;
          wr.mark_we   = visit_run;
          if (last_task) begin
            pend_d         = 1'b1;
            rreset_d       = dip_next >= task_count_q;
            wr.clear_all   = dip_next >= task_count_q;
            visit_pos_d    = '0;
            done_in_pass_d = '0;
          end else begin
            pend_d         = 1'b0;
            rreset_d       = 1'b0;
            visit_pos_d    = visit_pos_q + IdxW'(1);
            done_in_pass_d = dip_next;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      task_count_q   <= '0;
      visit_pos_q    <= '0;
      done_in_pass_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      task_count_q   <= task_count_d;
      visit_pos_q    <= visit_pos_d;
      done_in_pass_q <= done_in_pass_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      energy_q <= energy_w;
      cond_q   <= condition_met_i;
    end
    task_index_q <= task_index_d;
    add_acc_q    <= add_acc_d;
    run_q        <= run_d;
    was_q        <= was_d;
    pend_q       <= pend_d;
    rreset_q     <= rreset_d;
  end

  // the store reads the current pass position every cycle, so the data is
  // ready in the cycle after a visit is taken
  egts_store #(
    .MAX_TASKS  (MAX_TASKS),
    .ENERGY_BITS(ENERGY_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .add_addr_i (task_count_q[IdxW-1:0]),
    .add_need_i (need_w),
    .mark_addr_i(visit_pos_q),
    .rd_addr_i  (visit_pos_q),
    .rd_need_o  (rd_need),
    .rd_done_o  (rd_done)
  );

  assign out_valid_o    = out_valid_q;
  assign task_index_o   = task_index_q;
  assign add_accepted_o = add_acc_q;
  assign run_task_o     = run_q;
  assign was_complete_o = was_q;
  assign pass_end_o     = pend_q;
  assign round_reset_o  = rreset_q;

  // a visit always enters evaluation with a free result slot
  a_visit_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OpVisit) |=> state_q == ST_EVAL && !out_valid_q)
    else $error("visit did not enter evaluation with a free result slot");

  // a task cannot fire and be already complete at once
  a_run_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(run_task_o && was_complete_o))
    else $error("run and already-complete both set");

  // round reset only at the end of a pass, never on an add
  a_rreset_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && round_reset_o |-> pass_end_o && !add_accepted_o)
    else $error("round reset outside a pass end");

  // pass position stays inside the table
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (visit_pos_q == '0) || (CntW'(visit_pos_q) < task_count_q))
    else $error("pass position beyond the task count");

  // counters stay in range
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (task_count_q <= CntW'(MAX_TASKS)) && (done_in_pass_q <= task_count_q))
    else $error("task or pass counter out of range");

endmodule
